// ===== rtl/ddd_pkg.sv =====
// Shared constants and helper functions for the dissolve, dim and dither pixel block.
`timescale 1ns / 1ps

package ddd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_DISSOLVE  = 3'd1;
    localparam logic [2:0] REG_BRIGHT    = 3'd2;
    localparam logic [2:0] REG_ROW_WIDTH = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_LAYOUT    = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 30;

    // Reset values of the configuration registers.
    localparam logic [16:0] DISSOLVE_RST  = 17'd0;
    localparam logic [9:0]  BRIGHT_RST    = 10'd256;
    localparam logic [10:0] ROW_WIDTH_RST = 11'd1024;
    localparam logic [7:0]  THRESHOLD_RST = 8'd127;
    localparam logic [29:0] LAYOUT_RST    = 30'd268706064;

    localparam logic [16:0] T_ONE = 17'h10000;

    // Luma weights in Q16.
    localparam logic [15:0] GRAY_WR = 16'd19595;
    localparam logic [15:0] GRAY_WG = 16'd38470;
    localparam logic [15:0] GRAY_WB = 16'd7471;

    // Diffusion weights in sixteenths.
    localparam logic [3:0] SHARE_SIDE   = 4'd5;
    localparam logic [3:0] SHARE_DIAG   = 4'd3;
    localparam logic [3:0] SHARE_FOLD   = 4'd8;

    // One channel of the truecolor word: saturate, keep the top bits, place them.
    function automatic logic [31:0] pack_channel(input logic [10:0] c,
                                                 input logic [4:0] shift,
                                                 input logic [4:0] bits);
        logic [7:0]  v;
        logic [63:0] w;
        v = (c > 11'd255) ? 8'd255 : c[7:0];
        w = {56'd0, v} << bits;
        w = w >> 8;
        w = w << shift;
        return w[31:0];
    endfunction

endpackage

// ===== rtl/dissolve_dim_dither_pixel.sv =====
// Top level: pixel dissolve, dimming, truecolor packing and 1-bit error diffusion.
`timescale 1ns / 1ps

// One pixel beat is taken at a time; the next is not accepted until the last one has
// been loaded into the result register. The blend and luma multipliers run in three
// registered steps, and for a mono pixel the read-modify-write of the two error row
// memories then uses their single write port for five updates in turn.
// After reset the block clears both error rows, one entry per cycle, and holds
// in_stall high until the clear is done; configuration writes are taken throughout.
// The result register lets a finished beat wait while the next pixel is worked on.
module dissolve_dim_dither_pixel #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned ERROR_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ddd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     src_red,
    input  logic [7:0]                     src_green,
    input  logic [7:0]                     src_blue,
    input  logic [7:0]                     dst_red,
    input  logic [7:0]                     dst_green,
    input  logic [7:0]                     dst_blue,
    input  logic                           dst_present,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    true_pixel,
    output logic                           mono_bit,
    output logic                           byte_ready,
    output logic [7:0]                     packed_byte,
    output logic [6:0]                     byte_column,
    output logic                           row_end
);
    import ddd_pkg::*;

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW = (AW + 1 > 11) ? AW + 1 : 11;
    localparam int unsigned EB = ERROR_BITS;
    localparam int unsigned VW = ((EB > 12) ? EB : 12) + 1;
    localparam int unsigned EW = VW + 1;

    localparam logic signed [EW:0] ERR_HI = (EW + 1)'((1 << (EB - 1)) - 1);
    localparam logic signed [EW:0] ERR_LO = -ERR_HI - (EW + 1)'(1);
    localparam logic [WW-1:0] WIDTH_MAX = WW'(MAX_WIDTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MIX, ST_DIM, ST_GRAY, ST_GSUM,
        ST_ERR, ST_UPD1, ST_UPD2, ST_UPD3, ST_DONE
    } state_t;

    // Saturating add of a share into a stored error entry.
    function automatic logic [EB-1:0] sat_add(input logic [EB-1:0] a,
                                              input logic [EW-1:0] b);
        logic signed [EW:0] s;
        s = $signed({{(EW + 1 - EB){a[EB-1]}}, a}) + $signed({b[EW-1], b});
        if (s > ERR_HI)
        begin
            s = ERR_HI;
        end
        else if (s < ERR_LO)
        begin
            s = ERR_LO;
        end
        return s[EB-1:0];
    endfunction

    // Share of the pixel error in sixteenths, truncated toward zero.
    function automatic logic [EW-1:0] share(input logic [EW-1:0] e, input logic [3:0] k);
        logic signed [EW+3:0] p;
        logic signed [EW+3:0] q;
        p = $signed({{4{e[EW-1]}}, e}) * $signed((EW + 4)'(k));
        if (p < 0)
        begin
            q = (p + $signed((EW + 4)'(15))) >>> 4;
        end
        else
        begin
            q = p >>> 4;
        end
        return q[EW-1:0];
    endfunction

    // Configuration registers.
    logic        mode_reg;
    logic [16:0] dissolve_reg;
    logic [9:0]  bright_reg;
    logic [10:0] row_width_reg;
    logic [7:0]  threshold_reg;
    logic [29:0] layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            dissolve_reg  <= DISSOLVE_RST;
            bright_reg    <= BRIGHT_RST;
            row_width_reg <= ROW_WIDTH_RST;
            threshold_reg <= THRESHOLD_RST;
            layout_reg    <= LAYOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_DISSOLVE:  dissolve_reg  <= cfg_data[16:0];
                REG_BRIGHT:    bright_reg    <= cfg_data[9:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_data[10:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                REG_LAYOUT:    layout_reg    <= cfg_data[29:0];
                default:       ;
            endcase
        end
    end

    state_t          state_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   col_reg;
    logic [7:0]      acc_reg;
    logic            bufsel_reg;

    logic [7:0]      src_reg [3];
    logic [7:0]      dst_reg [3];
    logic            present_reg;
    logic [8:0]      mix_reg [3];
    logic [10:0]     chan_reg [3];
    logic [26:0]     gprod_reg [3];
    logic [10:0]     gray_reg;
    logic [31:0]     word_reg;
    logic            bit_reg;
    logic [EW-1:0]   s5_reg;
    logic [EW-1:0]   s3_reg;
    logic [EW-1:0]   s8_reg;
    logic [EB-1:0]   nx_reg;

    logic            out_valid_reg;
    logic [31:0]     true_pixel_reg;
    logic            mono_bit_reg;
    logic            byte_ready_reg;
    logic [7:0]      packed_byte_reg;
    logic [6:0]      byte_column_reg;
    logic            row_end_reg;

    // Column arithmetic.
    logic [WW-1:0] w_eff;
    logic [WW-1:0] x_ext;
    logic          last;
    logic [AW-1:0] x_inc;
    logic [AW-1:0] x_dec;
    logic          x_zero;

    always_comb
    begin
        if (row_width_reg == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (WW'(row_width_reg) > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        else
        begin
            w_eff = WW'(row_width_reg);
        end
        x_ext  = WW'(col_reg);
        last   = (x_ext + WW'(1)) >= w_eff;
        x_inc  = AW'(x_ext + WW'(1));
        x_dec  = AW'(x_ext - WW'(1));
        x_zero = (col_reg == '0);
    end

    // Blend front end.
    logic [16:0] t_sat;
    logic [16:0] t_inv;
    logic [8:0]  mix_next [3];
    logic [10:0] chan_next [3];

    always_comb
    begin
        logic [24:0] pa;
        logic [24:0] pb;
        logic [18:0] pd;
        t_sat = (dissolve_reg > T_ONE) ? T_ONE : dissolve_reg;
        t_inv = T_ONE - t_sat;
        for (int i = 0; i < 3; i++)
        begin
            pa = t_inv * src_reg[i];
            pb = present_reg ? (t_sat * dst_reg[i]) : 25'd0;
            mix_next[i] = {1'b0, pa[23:16]} + {1'b0, pb[23:16]};
            pd = (bright_reg * mix_reg[i]) + 19'd128;
            chan_next[i] = pd[18:8];
        end
    end

    // Memory ports, seen as current row and next row.
    logic            cur_we;
    logic [AW-1:0]   cur_waddr;
    logic [EB-1:0]   cur_wdata;
    logic [AW-1:0]   cur_raddr;
    logic [EB-1:0]   cur_rdata;
    logic            nxt_we;
    logic [AW-1:0]   nxt_waddr;
    logic [EB-1:0]   nxt_wdata;
    logic [AW-1:0]   nxt_raddr;
    logic [EB-1:0]   nxt_rdata;

    logic            m0_we;
    logic [AW-1:0]   m0_waddr;
    logic [EB-1:0]   m0_wdata;
    logic [AW-1:0]   m0_raddr;
    logic [EB-1:0]   m0_rdata;
    logic            m1_we;
    logic [AW-1:0]   m1_waddr;
    logic [EB-1:0]   m1_wdata;
    logic [AW-1:0]   m1_raddr;
    logic [EB-1:0]   m1_rdata;

    logic [EB-1:0]   mem0 [MAX_WIDTH];
    logic [EB-1:0]   mem1 [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (m0_we)
        begin
            mem0[m0_waddr] <= m0_wdata;
        end
        m0_rdata <= mem0[m0_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m1_we)
        begin
            mem1[m1_waddr] <= m1_wdata;
        end
        m1_rdata <= mem1[m1_raddr];
    end

    assign cur_rdata = bufsel_reg ? m1_rdata : m0_rdata;
    assign nxt_rdata = bufsel_reg ? m0_rdata : m1_rdata;

    // Pixel error from the gray value and the error carried to this pixel.
    logic signed [VW-1:0] v_sum;
    logic [7:0]           v_clamp;
    logic                 white;
    logic [EW-1:0]        err;
    logic [EB-1:0]        nx_fold;

    always_comb
    begin
        v_sum = $signed({{(VW - 11){1'b0}}, gray_reg})
              + $signed({{(VW - EB){cur_rdata[EB-1]}}, cur_rdata});
        if (v_sum > $signed(VW'(255)))
        begin
            v_clamp = 8'd255;
        end
        else if (v_sum < 0)
        begin
            v_clamp = 8'd0;
        end
        else
        begin
            v_clamp = v_sum[7:0];
        end
        white = v_clamp > threshold_reg;
        err   = EW'($signed({v_sum[VW-1], v_sum}) - (white ? $signed(EW'(255)) : $signed(EW'(0))));

        nx_fold = sat_add(nx_reg, s5_reg);
        if (last)
        begin
            nx_fold = sat_add(nx_fold, s8_reg);
        end
        if (x_zero)
        begin
            nx_fold = sat_add(nx_fold, s3_reg);
        end
    end

    always_comb
    begin
        cur_we    = 1'b0;
        cur_waddr = col_reg;
        cur_wdata = '0;
        cur_raddr = col_reg;
        nxt_we    = 1'b0;
        nxt_waddr = col_reg;
        nxt_wdata = '0;
        nxt_raddr = col_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_waddr = clr_reg;
                nxt_we    = 1'b1;
                nxt_waddr = clr_reg;
            end
            ST_ERR:
            begin
                cur_raddr = x_inc;
                nxt_raddr = x_inc;
                cur_we    = 1'b1;
            end
            ST_UPD1:
            begin
                cur_we    = !last;
                cur_waddr = x_inc;
                cur_wdata = sat_add(cur_rdata, s5_reg);
                nxt_we    = !last;
                nxt_waddr = x_inc;
                nxt_wdata = sat_add(nxt_rdata, s3_reg);
                nxt_raddr = x_dec;
            end
            ST_UPD2:
            begin
                nxt_we    = !x_zero;
                nxt_waddr = x_dec;
                nxt_wdata = sat_add(nxt_rdata, s3_reg);
            end
            ST_UPD3:
            begin
                nxt_we    = 1'b1;
                nxt_wdata = nx_fold;
            end
            default:
            begin
            end
        endcase

        if (bufsel_reg)
        begin
            m1_we = cur_we; m1_waddr = cur_waddr; m1_wdata = cur_wdata; m1_raddr = cur_raddr;
            m0_we = nxt_we; m0_waddr = nxt_waddr; m0_wdata = nxt_wdata; m0_raddr = nxt_raddr;
        end
        else
        begin
            m0_we = cur_we; m0_waddr = cur_waddr; m0_wdata = cur_wdata; m0_raddr = cur_raddr;
            m1_we = nxt_we; m1_waddr = nxt_waddr; m1_wdata = nxt_wdata; m1_raddr = nxt_raddr;
        end
    end

    // Bit packing for the result beat.
    logic [7:0] acc_or;
    logic       ready;
    logic       can_load;

    always_comb
    begin
        acc_or   = acc_reg | (8'({7'd0, bit_reg}) << (3'd7 - col_reg[2:0]));
        ready    = mode_reg && ((col_reg[2:0] == 3'd7) || last);
        can_load = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            col_reg       <= '0;
            acc_reg       <= 8'd0;
            bufsel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In ST_DONE the result register is either reloaded or still stalled.
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == ADDR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        src_reg[0]  <= src_red;
                        src_reg[1]  <= src_green;
                        src_reg[2]  <= src_blue;
                        dst_reg[0]  <= dst_red;
                        dst_reg[1]  <= dst_green;
                        dst_reg[2]  <= dst_blue;
                        present_reg <= dst_present;
                        state_reg   <= ST_MIX;
                    end
                end
                ST_MIX:
                begin
                    mix_reg   <= mix_next;
                    state_reg <= ST_DIM;
                end
                ST_DIM:
                begin
                    chan_reg  <= chan_next;
                    state_reg <= ST_GRAY;
                end
                ST_GRAY:
                begin
                    word_reg <= pack_channel(chan_reg[0], layout_reg[4:0], layout_reg[9:5])
                              | pack_channel(chan_reg[1], layout_reg[14:10], layout_reg[19:15])
                              | pack_channel(chan_reg[2], layout_reg[24:20], layout_reg[29:25]);
                    gprod_reg[0] <= GRAY_WR * chan_reg[0];
                    gprod_reg[1] <= GRAY_WG * chan_reg[1];
                    gprod_reg[2] <= GRAY_WB * chan_reg[2];
                    bit_reg      <= 1'b0;
                    state_reg    <= mode_reg ? ST_GSUM : ST_DONE;
                end
                ST_GSUM:
                begin
                    gray_reg  <= 11'((28'(gprod_reg[0]) + 28'(gprod_reg[1])
                                    + 28'(gprod_reg[2])) >> 16);
                    state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    bit_reg   <= !white;
                    s5_reg    <= share(err, SHARE_SIDE);
                    s3_reg    <= share(err, SHARE_DIAG);
                    s8_reg    <= share(err, SHARE_FOLD);
                    nx_reg    <= nxt_rdata;
                    state_reg <= ST_UPD1;
                end
                ST_UPD1:
                begin
                    state_reg <= ST_UPD2;
                end
                ST_UPD2:
                begin
                    state_reg <= ST_UPD3;
                end
                ST_UPD3:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (can_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        true_pixel_reg  <= mode_reg ? 32'd0 : word_reg;
                        mono_bit_reg    <= mode_reg && bit_reg;
                        byte_ready_reg  <= ready;
                        packed_byte_reg <= ready ? acc_or : 8'd0;
                        byte_column_reg <= ready ? 7'(x_ext >> 3) : 7'd0;
                        row_end_reg     <= last;
                        if (last || ready)
                        begin
                            acc_reg <= 8'd0;
                        end
                        else if (mode_reg)
                        begin
                            acc_reg <= acc_or;
                        end
                        col_reg <= last ? '0 : x_inc;
                        if (mode_reg && last)
                        begin
                            bufsel_reg <= !bufsel_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign true_pixel  = true_pixel_reg;
    assign mono_bit    = mono_bit_reg;
    assign byte_ready  = byte_ready_reg;
    assign packed_byte = packed_byte_reg;
    assign byte_column = byte_column_reg;
    assign row_end     = row_end_reg;

endmodule

// ===== rtl/ddd_check.sv =====
// Port-level checks for the dissolve, dim and dither pixel block, bound to the top level.
`timescale 1ns / 1ps

module ddd_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] true_pixel,
    input logic        mono_bit,
    input logic        byte_ready,
    input logic [7:0]  packed_byte,
    input logic [6:0]  byte_column,
    input logic        row_end
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(true_pixel) && $stable(mono_bit)
            && $stable(byte_ready) && $stable(packed_byte) && $stable(byte_column)
            && $stable(row_end))
        else $error("result beat changed while stalled");

    // Without a byte the byte fields read zero.
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_ready |-> packed_byte == 8'd0 && byte_column == 7'd0)
        else $error("byte fields set without byte_ready");

    // A truecolor word never comes with mono fields.
    a_mode_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && true_pixel != 32'd0 |-> !mono_bit && !byte_ready)
        else $error("truecolor and mono fields mixed");

    // A set mono bit on the last pixel of a row comes with its byte flushed.
    a_row_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mono_bit && row_end |-> byte_ready)
        else $error("row ended without flushing its byte");

endmodule

bind dissolve_dim_dither_pixel ddd_check u_ddd_check (.*);
